### rtl/core/lsu_pkg.sv
package lsu_pkg;

   // fraction width of the 0.32 probabilities
   localparam int unsigned FracW = 32;
   // active count width and saturation value
   localparam int unsigned ActW = 13;
   localparam logic [ActW-1:0] ActMax = 13'h1FFF;
   // largest lattice side; site index and active count widths are sized for it
   localparam int unsigned MaxSide = 64;
   // register indexes of the configuration port
   localparam logic [1:0] CsrInfectProb = 2'd0;
   localparam logic [1:0] CsrSideLen = 2'd1;
   localparam logic [1:0] CsrMaxSweeps = 2'd2;

endpackage

### rtl/core/lattice_sis_site_update.sv
// lattice_sis_site_update: one Monte Carlo visit of an SIS lattice per word.
// Each request word carries a uniform 0.32 random fraction; the block applies
// it to the next site in raster order and returns one response word with the
// site index, its new state, the active count, sweep status and run status.
// Configuration (infection probability, side length, sweep limit) is to be
// written through the csr_ port only while no word is in flight; the block
// itself does not enforce this. An infected site below full active fraction
// goes through ST_READ, ST_DECIDE, a restoring divider in ST_DIV that yields
// one quotient bit per cycle for the active fraction, and the power in ST_MUL:
// its first pass copies the fraction, each further pass goes through ST_MUL
// and ST_MULW on a single shared 32x32 multiplier. An infected site at full
// active fraction skips the divider and steps the power without multiplying,
// a susceptible site goes from ST_DECIDE to ST_APPLY, and a word after the
// run has ended is answered from ST_IDLE. One word is in the block at a time;
// the next request is taken the cycle after the handoff. The response sits in
// an output register; while rsp_stall is high it holds and no new request is
// taken. Synchronous reset clears all MaxSide*MaxSide sites (4096), one site
// per cycle, during which req_stall stays high; configuration writes are taken.
module lattice_sis_site_update #(
   parameter int unsigned RECOVERY_POWER = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_random_fraction,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [11:0]          rsp_site_index,
   output logic                 rsp_site_infected,
   output logic [12:0]          rsp_active_count,
   output logic                 rsp_sweep_done,
   output logic [15:0]          rsp_sweep_number,
   output logic                 rsp_finished,
   output logic                 rsp_dropped_below,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import lsu_pkg::*;

   localparam int unsigned PosW = (MaxSide > 1) ? $clog2(MaxSide) : 1;
   localparam int unsigned SideW = $clog2(MaxSide + 1);
   localparam int unsigned Depth = MaxSide * MaxSide;
   localparam int unsigned AddrW = 2 * PosW;
   localparam int unsigned AreaW = 2 * SideW;
   localparam int unsigned PowW = $clog2(RECOVERY_POWER + 1);
   localparam int unsigned DivW = FracW + 1;
   localparam int unsigned DivCntW = $clog2(DivW + 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_DIV, ST_MUL, ST_MULW,
      ST_APPLY, ST_OUT
   } state_type;

   // configuration registers
   logic [31:0] infect_prob_ff;
   logic [6:0]  side_len_ff;
   logic [15:0] max_sweeps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         infect_prob_ff <= '0;
         side_len_ff <= 7'd32;
         max_sweeps_ff <= 16'd1000;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrInfectProb: infect_prob_ff <= csr_data;
            CsrSideLen: side_len_ff <= csr_data[6:0];
            CsrMaxSweeps: max_sweeps_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // effective side and area
   logic [SideW-1:0] side_eff;
   logic [AreaW-1:0] area;
   always_comb begin
      if (side_len_ff == 7'd0) side_eff = SideW'(1);
      else if (32'(side_len_ff) > MaxSide) side_eff = SideW'(MaxSide);
      else side_eff = SideW'(side_len_ff);
   end
   assign area = AreaW'(side_eff) * AreaW'(side_eff);

   // site memory
   logic site_mem [Depth];
   logic site_rd_ff;
   logic mem_we;
   logic [AddrW-1:0] mem_wa;
   logic mem_wd;

   state_type state_ff;
   logic [AddrW-1:0] clr_ff;
   logic [PosW-1:0] row_ff, col_ff;
   logic [ActW-1:0] active_ff;
   logic started_ff, over_ff, success_ff;
   logic [15:0] sweeps_ff;
   logic [31:0] rnd_ff;
   logic new_state_ff;
   // divider
   logic [DivW-1:0] quo_ff;
   logic [AreaW:0] rem_ff;
   logic [DivCntW-1:0] dcnt_ff;
   // power
   logic [FracW:0] frac_ff, pow_ff;
   logic [PowW-1:0] pcnt_ff;
   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      if (mem_we) site_mem[mem_wa] <= mem_wd;
      site_rd_ff <= site_mem[{row_ff, col_ff}];
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = {row_ff, col_ff};
      mem_wd = new_state_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = 1'b0;
      end else if (state_ff == ST_APPLY) begin
         mem_we = 1'b1;
      end
   end

   // divider step: remainder shifted in, compared with the area
   logic [AreaW+1:0] rem_sh;
   assign rem_sh = {rem_ff, 1'b0};

   // row and sweep advance
   logic [PosW:0] col_nx, row_nx;
   logic row_end, swept;
   assign col_nx = {1'b0, col_ff} + 1'b1;
   assign row_nx = {1'b0, row_ff} + 1'b1;
   assign row_end = (SideW + 1)'(col_nx) >= (SideW + 1)'(side_eff);
   assign swept = row_end && ((SideW + 1)'(row_nx) >= (SideW + 1)'(side_eff));

   logic [ActW-1:0] act_new;
   logic [15:0] sweeps_new;
   logic [15:0] limit;
   always_comb begin
      act_new = active_ff;
      if (new_state_ff != site_rd_ff) begin
         if (new_state_ff) act_new = (active_ff != '0) ? active_ff - 1'b1 : active_ff;
         else act_new = (active_ff != ActMax) ? active_ff + 1'b1 : active_ff;
      end
      sweeps_new = (sweeps_ff != 16'hFFFF) ? sweeps_ff + 1'b1 : sweeps_ff;
      limit = (max_sweeps_ff == '0) ? 16'd1 : max_sweeps_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         active_ff <= '0;
         started_ff <= 1'b0;
         over_ff <= 1'b0;
         success_ff <= 1'b0;
         sweeps_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == Depth - 1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  rnd_ff <= req_random_fraction;
                  if (over_ff) begin
                     rsp_site_index <= '0;
                     rsp_site_infected <= 1'b0;
                     rsp_active_count <= active_ff;
                     rsp_sweep_done <= 1'b0;
                     rsp_sweep_number <= sweeps_ff;
                     rsp_finished <= 1'b1;
                     rsp_dropped_below <= success_ff;
                     rsp_valid <= 1'b1;
                     state_ff <= ST_OUT;
                  end else begin
                     if (!started_ff) begin
                        active_ff <= ActW'(area);
                        started_ff <= 1'b1;
                     end
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               if (site_rd_ff) begin
                  if ((AreaW + 1)'(active_ff) >= (AreaW + 1)'(area)) begin
                     frac_ff <= {1'b1, {FracW{1'b0}}};
                     pow_ff <= {1'b1, {FracW{1'b0}}};
                     pcnt_ff <= '0;
                     dcnt_ff <= '0;
                     state_ff <= ST_MUL;
                  end else begin
                     rem_ff <= (AreaW + 1)'(active_ff);
                     quo_ff <= '0;
                     dcnt_ff <= '0;
                     state_ff <= ST_DIV;
                  end
               end else begin
                  new_state_ff <= (rnd_ff < infect_prob_ff);
                  state_ff <= ST_APPLY;
               end
            end
            ST_DIV: begin
               // first step uses active itself (bit 32 of quotient, always 0)
               if (dcnt_ff == '0) begin
                  quo_ff <= '0;
               end else if (rem_sh >= (AreaW + 2)'(area)) begin
                  rem_ff <= (AreaW + 1)'(rem_sh - (AreaW + 2)'(area));
                  quo_ff <= {quo_ff[DivW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[AreaW:0];
                  quo_ff <= {quo_ff[DivW-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
               if (32'(dcnt_ff) == DivW - 1) begin
                  pow_ff <= {1'b1, {FracW{1'b0}}};
                  pcnt_ff <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (dcnt_ff == DivCntW'(DivW) && pcnt_ff == '0) begin
                  frac_ff <= quo_ff;
                  dcnt_ff <= '0;
               end else if (32'(pcnt_ff) == RECOVERY_POWER) begin
                  new_state_ff <= !({1'b0, rnd_ff} < pow_ff);
                  state_ff <= ST_APPLY;
               end else if (pow_ff[FracW]) begin
                  pow_ff <= frac_ff;
                  pcnt_ff <= pcnt_ff + 1'b1;
               end else if (frac_ff[FracW]) begin
                  pcnt_ff <= pcnt_ff + 1'b1;
               end else begin
                  prod_ff <= pow_ff[FracW-1:0] * frac_ff[FracW-1:0];
                  state_ff <= ST_MULW;
               end
            end
            ST_MULW: begin
               pow_ff <= {1'b0, prod_ff[63:32]};
               pcnt_ff <= pcnt_ff + 1'b1;
               state_ff <= ST_MUL;
            end
            ST_APPLY: begin
               active_ff <= act_new;
               rsp_site_index <= 12'(AreaW'(row_ff) * AreaW'(side_eff) + AreaW'(col_ff));
               rsp_site_infected <= new_state_ff;
               rsp_active_count <= act_new;
               rsp_sweep_done <= swept;
               if (row_end) begin
                  col_ff <= '0;
                  row_ff <= swept ? '0 : PosW'(row_nx);
               end else begin
                  col_ff <= PosW'(col_nx);
               end
               rsp_sweep_number <= swept ? sweeps_new : sweeps_ff;
               rsp_finished <= 1'b0;
               rsp_dropped_below <= 1'b0;
               if (swept) begin
                  sweeps_ff <= sweeps_new;
                  if ((AreaW + 4)'(act_new) * (AreaW + 4)'(10) < (AreaW + 4)'(area)) begin
                     over_ff <= 1'b1;
                     success_ff <= 1'b1;
                     rsp_finished <= 1'b1;
                     rsp_dropped_below <= 1'b1;
                  end else if (sweeps_new >= limit) begin
                     over_ff <= 1'b1;
                     rsp_finished <= 1'b1;
                  end
               end
               rsp_valid <= 1'b1;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### test/lattice_sis_site_update_tb.sv
`timescale 1ns / 100ps

module lattice_sis_site_update_tb;
   import lsu_pkg::*;

   localparam int unsigned SideMax = 64;
   localparam int unsigned PowerN = 5;
   localparam longint unsigned UnitQ32 = 64'h1_0000_0000;
   localparam int unsigned CycleLimit = 600000;

   typedef struct packed {
      logic [11:0] idx;
      logic        infected;
      logic [12:0] active;
      logic        swept;
      logic [15:0] sweeps;
      logic        fin;
      logic        success;
   } site_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_random_fraction = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_site_index;
   logic        rsp_site_infected;
   logic [12:0] rsp_active_count;
   logic        rsp_sweep_done;
   logic [15:0] rsp_sweep_number;
   logic        rsp_finished;
   logic        rsp_dropped_below;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // lattice model state and register copies
   logic [31:0] infect_level;
   logic [6:0]  side_reg;
   logic [15:0] sweep_limit;
   bit          lattice [SideMax][SideMax];
   int unsigned active_sites;
   bit          seeded;
   int unsigned row_pos;
   int unsigned col_pos;
   int unsigned sweep_count;
   bit          epidemic_over;
   bit          died_out;

   site_word_type pending_words[$];
   int          errors = 0;
   int          words_checked = 0;
   int          sweeps_seen = 0;
   int unsigned cycles = 0;
   bit          quiet = 1'b0;
   int          hold_left = 0;

   lattice_sis_site_update uut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("lattice_sis_site_update_tb: errors");
         $finish;
      end
   end

   // (active / area)^power as 0.32, 2^32 standing for one
   function automatic longint unsigned recovery_level(int unsigned area);
      longint unsigned frac;
      longint unsigned p;
      p = UnitQ32;
      if (active_sites >= area) frac = UnitQ32;
      else frac = (longint'(active_sites) << 32) / area;
      for (int n = 0; n < PowerN; n++) begin
         if (p == UnitQ32) p = frac;
         else if (frac != UnitQ32) p = (p * frac) >> 32;
      end
      return p;
   endfunction

   function automatic site_word_type visit_site(logic [31:0] rnd);
      site_word_type w;
      int unsigned side;
      int unsigned area;
      int unsigned r;
      int unsigned c;
      int unsigned lim;
      bit          swept;
      w = '0;
      swept = 1'b0;
      if (epidemic_over) begin
         w.active = active_sites[12:0];
         w.sweeps = sweep_count[15:0];
         w.fin = 1'b1;
         w.success = died_out;
         return w;
      end
      side = (side_reg == 0) ? 1 : (side_reg > SideMax) ? SideMax : side_reg;
      area = side * side;
      if (!seeded) begin
         active_sites = area;
         seeded = 1'b1;
      end
      r = row_pos % SideMax;
      c = col_pos % SideMax;
      if (lattice[r][c]) begin
         if (longint'(rnd) < recovery_level(area)) begin
            lattice[r][c] = 1'b0;
            if (active_sites < 8191) active_sites++;
         end
      end else if (rnd < infect_level) begin
         lattice[r][c] = 1'b1;
         if (active_sites > 0) active_sites--;
      end
      w.idx = 12'(r * side + c);
      w.infected = lattice[r][c];
      // raster advance
      if (c + 1 >= side) begin
         col_pos = 0;
         if (r + 1 >= side) begin
            row_pos = 0;
            swept = 1'b1;
         end else begin
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
      if (swept) begin
         if (sweep_count < 65535) sweep_count++;
         lim = (sweep_limit == 0) ? 1 : sweep_limit;
         if (longint'(active_sites) * 10 < area) begin
            epidemic_over = 1'b1;
            died_out = 1'b1;
         end else if (sweep_count >= lim) begin
            epidemic_over = 1'b1;
            died_out = 1'b0;
         end
      end
      w.active = active_sites[12:0];
      w.swept = swept;
      w.sweeps = sweep_count[15:0];
      w.fin = epidemic_over;
      w.success = died_out;
      return w;
   endfunction

   // register write, called at a falling edge
   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (index)
         CsrInfectProb: infect_level = value;
         CsrSideLen:    side_reg = value[6:0];
         CsrMaxSweeps:  sweep_limit = value[15:0];
         default: ;
      endcase
   endtask

   // one random fraction word into the block
   task automatic send_word(logic [31:0] rnd);
      site_word_type w;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_random_fraction = rnd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      w = visit_site(rnd);
      pending_words = {pending_words, w};
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // receiver stalls: random bursts, or a long hold when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (rsp_stall && $urandom_range(0, 14) != 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 9) == 0);
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      site_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
         end else begin
            w = pending_words.pop_front();
            check_field("site_index", w.idx, rsp_site_index);
            check_field("site_infected", w.infected, rsp_site_infected);
            check_field("active_count", w.active, rsp_active_count);
            check_field("sweep_done", w.swept, rsp_sweep_done);
            check_field("sweep_number", w.sweeps, rsp_sweep_number);
            check_field("finished", w.fin, rsp_finished);
            check_field("dropped_below", w.success, rsp_dropped_below);
            words_checked++;
            if (rsp_sweep_done) sweeps_seen++;
         end
      end
   end

   // reset-value registers, extreme randoms
   task automatic test_corner_randoms();
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      wait_idle();
      write_reg(CsrInfectProb, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFE);
      wait_idle();
   endtask

   // side length beyond the maximum and zero
   task automatic test_side_extremes();
      write_reg(CsrSideLen, 32'd127);
      send_word(32'h0000_0001);
      send_word(32'h8000_0000);
      wait_idle();
      write_reg(CsrSideLen, 32'd64);
      send_word(32'h7FFF_FFFF);
      wait_idle();
      write_reg(CsrSideLen, 32'd0);
      write_reg(CsrInfectProb, 32'd0);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      wait_idle();
   endtask

   // single-site lattice: infect, then recover at full active fraction
   task automatic test_unit_side_recovery();
      write_reg(CsrSideLen, 32'd1);
      write_reg(CsrMaxSweeps, 32'd65535);
      write_reg(CsrInfectProb, 32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      wait_idle();
      write_reg(CsrInfectProb, 32'd0);
      send_word(32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      send_word(32'h1234_5678);
      wait_idle();
   endtask

   // long receiver hold while words keep coming
   task automatic test_output_backpressure();
      write_reg(CsrSideLen, 32'd5);
      write_reg(CsrInfectProb, 32'h6000_0000);
      hold_left = 400;
      for (int i = 0; i < 6; i++) send_word($urandom);
      wait_idle();
   endtask

   // random chunks over many settings
   task automatic test_random_sweeps();
      int unsigned sides[6] = '{2, 3, 5, 8, 40, 64};
      for (int chunk = 0; chunk < 16; chunk++) begin
         write_reg(CsrSideLen, sides[$urandom_range(0, 5)]);
         case ($urandom_range(0, 3))
            0: write_reg(CsrInfectProb, $urandom);
            1: write_reg(CsrInfectProb, $urandom_range(0, 32'h1000_0000));
            default: write_reg(CsrInfectProb, $urandom_range(32'h4000_0000, 32'hA000_0000));
         endcase
         write_reg(CsrMaxSweeps, $urandom_range(2000, 65535));
         for (int i = 0; i < 32; i++) send_word($urandom);
         wait_idle();
      end
   endtask

   // sweep limit of one ends the run; later words change nothing
   task automatic test_run_end();
      quiet = 1'b1;
      write_reg(CsrSideLen, 32'd3);
      write_reg(CsrInfectProb, 32'h3000_0000);
      write_reg(CsrMaxSweeps, 32'd1);
      while (!epidemic_over) send_word($urandom);
      for (int i = 0; i < 6; i++) send_word($urandom);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      wait_idle();
   endtask

   initial begin
      infect_level = '0;
      side_reg = 7'd32;
      sweep_limit = 16'd1000;
      active_sites = 0;
      seeded = 1'b0;
      row_pos = 0;
      col_pos = 0;
      sweep_count = 0;
      epidemic_over = 1'b0;
      died_out = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_corner_randoms();
      test_side_extremes();
      test_unit_side_recovery();
      test_output_backpressure();
      test_random_sweeps();
      test_run_end();
      repeat (80) @(posedge clock);
      $display("%0d words checked over %0d sweeps, side lengths 1 to 64,", words_checked,
               sweeps_seen);
      $display("full and partial recovery, long output hold, run end by sweep limit");
      if (errors == 0) begin
         $display("lattice_sis_site_update_tb: clean");
      end else begin
         $display("lattice_sis_site_update_tb: errors");
      end
      $finish;
   end

endmodule

### lattice_sis_site_update.f
rtl/core/lsu_pkg.sv
rtl/core/lattice_sis_site_update.sv
test/lattice_sis_site_update_tb.sv
